>>> hdl/assert_macros.svh
// Assertion macros for the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define AEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/aeeval_pkg.sv
// Package: types, constants and helpers of the assignment expression evaluator.
package aeeval_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int ADD_W       = VALUE_WIDTH + 2;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int NUM_VARS    = 26;
    localparam int OUT_W       = 32;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [4:0]             t_var_idx;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LZ    = 8'd122;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_KEEP = 3'd5
    } t_op;

    // Where the parser is within the line.
    typedef enum logic [2:0] {
        PH_TARGET  = 3'd0,
        PH_EQUALS  = 3'd1,
        PH_OPERAND = 3'd2,
        PH_AFTER   = 3'd3,
        PH_INT     = 3'd4,
        PH_FRAC    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // Line status carried by a result transaction.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_UNDEF   = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [4:0]        target_var;
        logic signed [31:0] value;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic   done;
        t_value result;
    } t_alu_rsp;

    function automatic t_op op_code(input logic [7:0] c);
        t_op o;
        unique case (c)
            CH_PLUS:  o = OP_ADD;
            CH_MINUS: o = OP_SUB;
            CH_STAR:  o = OP_MUL;
            CH_SLASH: o = OP_DIV;
            CH_EQ:    o = OP_KEEP;
            default:  o = OP_NONE;
        endcase
        return o;
    endfunction

endpackage

>>> hdl/aeeval_alu.sv
// Shared arithmetic unit: one adder, iterated for shift-add multiply and restoring divide.
module aeeval_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aeeval_pkg::t_alu_req i_req,
    input  aeeval_pkg::t_value   i_a,
    input  aeeval_pkg::t_value   i_b,
    output aeeval_pkg::t_alu_rsp o_rsp
);

    localparam int W = aeeval_pkg::VALUE_WIDTH;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIX  = 4'b1000
    } t_alu_state;

    t_alu_state                       r_state;
    logic [aeeval_pkg::CNT_W-1:0]     r_cnt;
    aeeval_pkg::t_value               r_x;   // multiplicand, or dividend/quotient
    aeeval_pkg::t_value               r_y;   // multiplier, or divisor magnitude
    aeeval_pkg::t_value               r_acc; // product, or partial remainder
    logic                             r_neg;
    logic                             r_done;
    aeeval_pkg::t_value               r_result;

    logic [aeeval_pkg::ADD_W-1:0] w_add_a, w_add_b, w_sum;
    logic                         w_sub;
    logic                         w_last_step;
    aeeval_pkg::t_value           w_a_mag, w_b_mag;

    // the one adder
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        w_sub   = 1'b0;
        unique case (r_state)
            A_IDLE: begin
                w_add_a = {2'b00, i_a};
                w_add_b = {2'b00, i_b};
                w_sub   = (i_req.op == aeeval_pkg::OP_SUB);
            end
            A_MUL: begin
                w_add_a = {2'b00, r_acc};
                w_add_b = {2'b00, r_x};
            end
            A_DIV: begin
                w_add_a = {1'b0, r_acc, r_x[W-1]};
                w_add_b = {2'b00, r_y};
                w_sub   = 1'b1;
            end
            A_FIX: begin
                w_add_b = {2'b00, r_x};
                w_sub   = 1'b1;
            end
            default: ;
        endcase
        w_sum = w_add_a + (w_sub ? ~w_add_b : w_add_b) + aeeval_pkg::ADD_W'(w_sub);
    end

    assign w_a_mag     = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign w_b_mag     = i_b[W-1] ? (~i_b + W'(1)) : i_b;
    assign w_last_step = (r_cnt == aeeval_pkg::CNT_W'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        case (i_req.op)
                            aeeval_pkg::OP_ADD, aeeval_pkg::OP_SUB: begin
                                r_result <= w_sum[W-1:0];
                                r_done   <= 1'b1;
                            end
                            aeeval_pkg::OP_MUL: begin
                                r_x     <= i_a;
                                r_y     <= i_b;
                                r_state <= A_MUL;
                            end
                            aeeval_pkg::OP_DIV: begin
                                r_x     <= w_a_mag;
                                r_y     <= w_b_mag;
                                r_neg   <= i_a[W-1] ^ i_b[W-1];
                                r_state <= A_DIV;
                            end
                            default: begin
                                r_result <= i_a;
                                r_done   <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= w_sum[W-1:0];
                    end
                    r_x <= {r_x[W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[W-1:1]};
                    r_cnt <= r_cnt + aeeval_pkg::CNT_W'(1);
                    if (w_last_step) begin
                        r_result <= r_y[0] ? w_sum[W-1:0] : r_acc;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end
                end
                A_DIV: begin
                    // borrow clear: divisor fits, quotient bit is one
                    if (!w_sum[aeeval_pkg::ADD_W-1]) begin
                        r_acc <= w_sum[W-1:0];
                    end else begin
                        r_acc <= {r_acc[W-2:0], r_x[W-1]};
                    end
                    r_x   <= {r_x[W-2:0], ~w_sum[aeeval_pkg::ADD_W-1]};
                    r_cnt <= r_cnt + aeeval_pkg::CNT_W'(1);
                    if (w_last_step) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_result <= r_neg ? w_sum[W-1:0] : r_x;
                    r_done   <= 1'b1;
                    r_state  <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

>>> hdl/assignment_expression_evaluator_unit.sv
// Top level: character-serial left-to-right assignment evaluator with 26 variables.
// Flow: a character is accepted and then decoded; one that applies +, -, * or / waits on
//   the shared ALU, where * and / iterate its loop.
// The last character of a line also finishes it, first folding in a number that it
//   completes (through the ALU when that number applies an operator); the result then
//   sits in an output register, and a new line may start while it waits to be taken.
// Reset (synchronous, active low) clears all variable defined bits and line state at once.
`include "assert_macros.svh"

module assignment_expression_evaluator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  aeeval_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output aeeval_pkg::t_out_item o_out_data
);

    localparam int W = aeeval_pkg::VALUE_WIDTH;

    // Sequencer: idle/accept, decode one character, wait on the ALU, finish a line.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PARSE  = 4'b0010,
        S_EXEC   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    aeeval_pkg::t_value   r_acc, n_acc;
    aeeval_pkg::t_value   r_num, n_num;
    aeeval_pkg::t_op      r_pend, n_pend;
    aeeval_pkg::t_phase   r_phase, n_phase;
    aeeval_pkg::t_status  r_status, n_status;
    aeeval_pkg::t_var_idx r_target, n_target;

    // captured character of the current transaction
    logic [7:0] r_ch;
    logic       r_last;

    // variable file: values need no reset, defined bits do
    aeeval_pkg::t_value r_var_val [aeeval_pkg::NUM_VARS];
    logic [aeeval_pkg::NUM_VARS-1:0] r_var_def;

    aeeval_pkg::t_out_item r_out;
    logic                  r_out_valid;

    // decode of the captured character
    logic                 w_is_letter, w_is_digit;
    aeeval_pkg::t_op      w_op;
    aeeval_pkg::t_var_idx w_letter_idx;
    aeeval_pkg::t_value   w_digit;
    aeeval_pkg::t_value   w_num_x10;

    // operand application
    logic                 w_apply_en;
    aeeval_pkg::t_value   w_apply_v;
    aeeval_pkg::t_alu_req w_alu_req;
    aeeval_pkg::t_alu_rsp w_alu_rsp;

    logic                w_out_free;
    logic                w_emit;
    aeeval_pkg::t_status w_final_status;

    assign w_is_letter  = (r_ch >= aeeval_pkg::CH_LA) && (r_ch <= aeeval_pkg::CH_LZ);
    assign w_is_digit   = (r_ch >= aeeval_pkg::CH_ZERO) && (r_ch <= aeeval_pkg::CH_NINE);
    assign w_op         = aeeval_pkg::op_code(r_ch);
    assign w_letter_idx = 5'(r_ch - aeeval_pkg::CH_LA);
    assign w_digit      = W'(r_ch[3:0]);
    // n*10 as (n<<3)+(n<<1), wrapping at the value width
    assign w_num_x10    = {r_num[W-4:0], 3'b000} + {r_num[W-2:0], 1'b0};

    assign w_out_free     = !r_out_valid || i_out_ready;
    // by the time a line is emitted a trailing number has been folded in
    assign w_final_status = (r_phase != aeeval_pkg::PH_AFTER) ? aeeval_pkg::ST_SYNTAX : r_status;

    aeeval_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (r_acc),
        .i_b     (w_apply_v),
        .o_rsp   (w_alu_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_num      = r_num;
        n_pend     = r_pend;
        n_phase    = r_phase;
        n_status   = r_status;
        n_target   = r_target;
        w_apply_en = 1'b0;
        w_apply_v  = r_num;
        w_alu_req  = '0;
        w_alu_req.op = r_pend;
        w_emit     = 1'b0;

        // character decode and line bookkeeping
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PARSE;
                end
            end
            S_PARSE: begin
                n_state = r_last ? S_FINISH : S_IDLE;
                if (r_ch != aeeval_pkg::CH_SPACE) begin
                    case (r_phase)
                        aeeval_pkg::PH_TARGET: begin
                            if (w_is_letter) begin
                                n_target = w_letter_idx;
                                n_phase  = aeeval_pkg::PH_EQUALS;
                            end else begin
                                n_status = aeeval_pkg::ST_SYNTAX;
                                n_phase  = aeeval_pkg::PH_ERROR;
                            end
                        end
                        aeeval_pkg::PH_EQUALS: begin
                            if (r_ch == aeeval_pkg::CH_EQ) begin
                                n_pend  = aeeval_pkg::OP_NONE;
                                n_phase = aeeval_pkg::PH_OPERAND;
                            end else begin
                                n_status = aeeval_pkg::ST_SYNTAX;
                                n_phase  = aeeval_pkg::PH_ERROR;
                            end
                        end
                        aeeval_pkg::PH_OPERAND: begin
                            if (w_is_letter) begin
                                n_phase = aeeval_pkg::PH_AFTER;
                                if (r_status == aeeval_pkg::ST_OK) begin
                                    if (!r_var_def[w_letter_idx]) begin
                                        n_status = aeeval_pkg::ST_UNDEF;
                                    end else begin
                                        w_apply_en = 1'b1;
                                        w_apply_v  = r_var_val[w_letter_idx];
                                    end
                                end
                            end else if (w_is_digit) begin
                                n_num   = w_digit;
                                n_phase = aeeval_pkg::PH_INT;
                            end else begin
                                n_status = aeeval_pkg::ST_SYNTAX;
                                n_phase  = aeeval_pkg::PH_ERROR;
                            end
                        end
                        aeeval_pkg::PH_AFTER: begin
                            if (w_op != aeeval_pkg::OP_NONE) begin
                                n_pend  = w_op;
                                n_phase = aeeval_pkg::PH_OPERAND;
                            end else begin
                                n_status = aeeval_pkg::ST_SYNTAX;
                                n_phase  = aeeval_pkg::PH_ERROR;
                            end
                        end
                        aeeval_pkg::PH_INT, aeeval_pkg::PH_FRAC: begin
                            if (w_is_digit) begin
                                // fraction digits are dropped
                                if (r_phase == aeeval_pkg::PH_INT) begin
                                    n_num = w_num_x10 + w_digit;
                                end
                            end else if (r_ch == aeeval_pkg::CH_DOT &&
                                         r_phase == aeeval_pkg::PH_INT) begin
                                n_phase = aeeval_pkg::PH_FRAC;
                            end else if (w_op != aeeval_pkg::OP_NONE) begin
                                w_apply_en = 1'b1;
                                n_pend     = w_op;
                                n_phase    = aeeval_pkg::PH_OPERAND;
                            end else begin
                                n_status = aeeval_pkg::ST_SYNTAX;
                                n_phase  = aeeval_pkg::PH_ERROR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EXEC: begin
                if (w_alu_rsp.done) begin
                    n_acc   = w_alu_rsp.result;
                    n_state = r_last ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (r_phase == aeeval_pkg::PH_INT || r_phase == aeeval_pkg::PH_FRAC) begin
                    // fold in the number that the line ended on, then come back
                    w_apply_en = 1'b1;
                    n_phase    = aeeval_pkg::PH_AFTER;
                end else if (w_out_free) begin
                    w_emit   = 1'b1;
                    n_acc    = '0;
                    n_num    = '0;
                    n_pend   = aeeval_pkg::OP_NONE;
                    n_phase  = aeeval_pkg::PH_TARGET;
                    n_status = aeeval_pkg::ST_OK;
                    n_target = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // apply a completed operand under the pending operator; once the line
        // carries a status nothing more is evaluated
        if (w_apply_en && r_status == aeeval_pkg::ST_OK) begin
            case (r_pend)
                aeeval_pkg::OP_NONE: n_acc = w_apply_v;
                aeeval_pkg::OP_ADD, aeeval_pkg::OP_SUB, aeeval_pkg::OP_MUL: begin
                    w_alu_req.start = 1'b1;
                end
                aeeval_pkg::OP_DIV: begin
                    if (w_apply_v == '0) begin
                        n_acc    = '1;
                        n_status = aeeval_pkg::ST_DIVZERO;
                    end else begin
                        w_alu_req.start = 1'b1;
                    end
                end
                default: ; // '=' keeps the left value
            endcase
        end

        if (w_alu_req.start) begin
            n_state = S_EXEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_num    <= '0;
            r_pend   <= aeeval_pkg::OP_NONE;
            r_phase  <= aeeval_pkg::PH_TARGET;
            r_status <= aeeval_pkg::ST_OK;
            r_target <= '0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_num    <= n_num;
            r_pend   <= n_pend;
            r_phase  <= n_phase;
            r_status <= n_status;
            r_target <= n_target;
        end
    end

    // capture of the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch   <= i_in_data.ch;
            r_last <= i_in_data.line_end;
        end
    end

    // variable file: a good line, or one stopped by a zero divisor, assigns its target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_def <= '0;
        end else if (w_emit && (w_final_status == aeeval_pkg::ST_OK ||
                                w_final_status == aeeval_pkg::ST_DIVZERO)) begin
            r_var_def[r_target] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && (w_final_status == aeeval_pkg::ST_OK ||
                       w_final_status == aeeval_pkg::ST_DIVZERO)) begin
            r_var_val[r_target] <= r_acc;
        end
    end

    // output register decouples the result transaction from the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.status <= w_final_status;
            case (w_final_status)
                aeeval_pkg::ST_OK, aeeval_pkg::ST_DIVZERO: begin
                    r_out.target_var <= r_target;
                    r_out.value      <= aeeval_pkg::OUT_W'(r_acc);
                end
                aeeval_pkg::ST_UNDEF: begin
                    r_out.target_var <= r_target;
                    r_out.value      <= '0;
                end
                default: begin
                    r_out.target_var <= '0;
                    r_out.value      <= '0;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `AEE_ASSERT_IMP(a_out_target_range, i_clk, i_rst_n,
        o_out_valid, o_out_data.target_var <= 5'd25)
    `AEE_ASSERT_IMP(a_undef_value_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status == aeeval_pkg::ST_UNDEF, o_out_data.value == '0)
    `AEE_ASSERT_IMP(a_syntax_fields_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status == aeeval_pkg::ST_SYNTAX,
        o_out_data.value == '0 && o_out_data.target_var == '0)
    `AEE_ASSERT_IMP(a_alu_done_in_exec, i_clk, i_rst_n, w_alu_rsp.done, r_state == S_EXEC)
    `AEE_ASSERT_NXT(a_accept_to_parse, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_PARSE)

endmodule
